// ===== hdl/rmsp_pkg.sv =====
// Shared types and constants of the RMSprop parameter update pipeline.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rmsp_pkg;

	localparam int unsigned PARAM_W = 32;
	localparam int unsigned MS_W    = 48;
	localparam int unsigned RATE_W  = 32;
	localparam int unsigned DECAY_W = 17;
	localparam int unsigned PROD_W  = 64;
	localparam int unsigned QUOT_W  = 32;
	localparam int unsigned ROOT_W  = 25;
	localparam int unsigned RAD_W   = 2 * ROOT_W;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [DECAY_W-1:0] DECAY_ONE = 17'h10000;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ELEM_RATE = 2'd2;

	localparam logic [DECAY_W-1:0] DECAY_RESET     = 17'd58982;
	localparam logic [RATE_W-1:0]  BASE_RATE_RESET = 32'd16777;

	// Fields that ride alongside the step division.
	typedef struct packed {
		logic signed [PARAM_W-1:0] param;
		logic                      gneg;
		logic [MS_W-1:0]           ms;
		logic                      ms_sat;
		logic                      last;
	} post_t;

	// Fields that ride alongside the square root.
	typedef struct packed {
		post_t             post;
		logic [PROD_W-1:0] numer;
	} side_t;

	typedef struct packed {
		logic signed [PARAM_W-1:0] param;
		logic [MS_W-1:0]           ms;
		logic                      sat;
		logic                      last;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/rmsp_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with side payload.
// Depends on rmsp_pkg for widths and the side_t payload type.
`default_nettype none

module rmsp_isqrt import rmsp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_vld,
	input  wire logic [RAD_W-1:0] radicand,
	input  wire side_t            side_in,
	output logic                  out_vld,
	output logic [ROOT_W-1:0]     root,
	output side_t                 side_out
);

	localparam int unsigned REM_W = ROOT_W + 3;

	logic              vld_s  [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [RAD_W-1:0]  rad_s  [ROOT_W];
	side_t             side_s [ROOT_W];

	logic              feed_vld  [ROOT_W];
	logic [REM_W-1:0]  feed_rem  [ROOT_W];
	logic [ROOT_W-1:0] feed_root [ROOT_W];
	logic [RAD_W-1:0]  feed_rad  [ROOT_W];
	side_t             feed_side [ROOT_W];

	logic [REM_W-1:0]  nxt_rem  [ROOT_W];
	logic [ROOT_W-1:0] nxt_root [ROOT_W];

	always_comb begin
		feed_vld[0]  = in_vld;
		feed_rem[0]  = '0;
		feed_root[0] = '0;
		feed_rad[0]  = radicand;
		feed_side[0] = side_in;
		for (int j = 1; j < ROOT_W; j++) begin
			feed_vld[j]  = vld_s[j-1];
			feed_rem[j]  = rem_s[j-1];
			feed_root[j] = root_s[j-1];
			feed_rad[j]  = rad_s[j-1];
			feed_side[j] = side_s[j-1];
		end
	end

	// Each stage brings down the next two radicand bits and tries root*4+1.
	always_comb begin
		logic [REM_W-1:0] sh_rem;
		logic [REM_W-1:0] trial;
		for (int j = 0; j < ROOT_W; j++) begin
			sh_rem = {feed_rem[j][REM_W-3:0], feed_rad[j][RAD_W-1:RAD_W-2]};
			trial  = {{(REM_W-ROOT_W-2){1'b0}}, feed_root[j], 2'b01};
			if (sh_rem >= trial) begin
				nxt_rem[j]  = sh_rem - trial;
				nxt_root[j] = {feed_root[j][ROOT_W-2:0], 1'b1};
			end else begin
				nxt_rem[j]  = sh_rem;
				nxt_root[j] = {feed_root[j][ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < ROOT_W; j++) vld_s[j] <= 1'b0;
		end else if (adv) begin
			for (int j = 0; j < ROOT_W; j++) vld_s[j] <= feed_vld[j];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < ROOT_W; j++) begin
				rem_s[j]  <= nxt_rem[j];
				root_s[j] <= nxt_root[j];
				rad_s[j]  <= {feed_rad[j][RAD_W-3:0], 2'b00};
				side_s[j] <= feed_side[j];
			end
		end
	end

	assign out_vld  = vld_s[ROOT_W-1];
	assign root     = root_s[ROOT_W-1];
	assign side_out = side_s[ROOT_W-1];

endmodule

`default_nettype wire

// ===== hdl/rmsp_divider.sv =====
// Pipelined restoring divider for the step magnitude: a range check stage, then
// one quotient bit per stage. Depends on rmsp_pkg for widths and post_t.
`default_nettype none

module rmsp_divider import rmsp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_vld,
	input  wire logic [PROD_W-1:0] numer,
	input  wire logic [ROOT_W-1:0] divisor,
	input  wire post_t             post_in,
	output logic                   out_vld,
	output logic [QUOT_W-1:0]      quot,
	output logic                   ovf,
	output post_t                  post_out
);

	localparam int unsigned NSTG  = QUOT_W + 1;
	localparam int unsigned HI_W  = PROD_W - QUOT_W;

	logic              vld_s  [NSTG];
	logic [ROOT_W-1:0] rem_s  [NSTG];
	logic [QUOT_W-1:0] quot_s [NSTG];
	logic [QUOT_W-1:0] low_s  [NSTG];
	logic [ROOT_W-1:0] dvs_s  [NSTG];
	logic              ovf_s  [NSTG];
	post_t             post_s [NSTG];

	logic              nxt_vld  [NSTG];
	logic [ROOT_W-1:0] nxt_rem  [NSTG];
	logic [QUOT_W-1:0] nxt_quot [NSTG];
	logic [QUOT_W-1:0] nxt_low  [NSTG];
	logic [ROOT_W-1:0] nxt_dvs  [NSTG];
	logic              nxt_ovf  [NSTG];
	post_t             nxt_post [NSTG];

	// The first stage flags a quotient of 2^32 or more; such a step always
	// saturates the parameter, so only the low 32 quotient bits are formed.
	always_comb begin
		logic [ROOT_W:0] sh;
		nxt_vld[0]  = in_vld;
		nxt_ovf[0]  = numer[PROD_W-1:QUOT_W] >= {{(HI_W-ROOT_W){1'b0}}, divisor};
		nxt_rem[0]  = numer[QUOT_W+ROOT_W-1:QUOT_W];
		nxt_quot[0] = '0;
		nxt_low[0]  = numer[QUOT_W-1:0];
		nxt_dvs[0]  = divisor;
		nxt_post[0] = post_in;
		for (int j = 1; j < NSTG; j++) begin
			sh          = {rem_s[j-1], low_s[j-1][QUOT_W-1]};
			nxt_vld[j]  = vld_s[j-1];
			nxt_ovf[j]  = ovf_s[j-1];
			nxt_low[j]  = {low_s[j-1][QUOT_W-2:0], 1'b0};
			nxt_dvs[j]  = dvs_s[j-1];
			nxt_post[j] = post_s[j-1];
			if (sh >= {1'b0, dvs_s[j-1]}) begin
				nxt_rem[j]  = ROOT_W'(sh - {1'b0, dvs_s[j-1]});
				nxt_quot[j] = {quot_s[j-1][QUOT_W-2:0], 1'b1};
			end else begin
				nxt_rem[j]  = sh[ROOT_W-1:0];
				nxt_quot[j] = {quot_s[j-1][QUOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NSTG; j++) vld_s[j] <= 1'b0;
		end else if (adv) begin
			for (int j = 0; j < NSTG; j++) vld_s[j] <= nxt_vld[j];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < NSTG; j++) begin
				rem_s[j]  <= nxt_rem[j];
				quot_s[j] <= nxt_quot[j];
				low_s[j]  <= nxt_low[j];
				dvs_s[j]  <= nxt_dvs[j];
				ovf_s[j]  <= nxt_ovf[j];
				post_s[j] <= nxt_post[j];
			end
		end
	end

	assign out_vld  = vld_s[NSTG-1];
	assign quot     = quot_s[NSTG-1];
	assign ovf      = ovf_s[NSTG-1];
	assign post_out = post_s[NSTG-1];

endmodule

`default_nettype wire

// ===== hdl/rmsp_skid.sv =====
// Output register with a skid stage, so that the pipeline's enable is a
// registered signal. Depends on rmsp_pkg for result_t.
`default_nettype none

module rmsp_skid import rmsp_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    up_vld,
	input  wire result_t up_data,
	output logic         up_rdy,
	output logic         dn_vld,
	input  wire logic    dn_rdy,
	output result_t      dn_data
);

	logic    out_vld_q;
	logic    skid_vld_q;
	result_t out_data_q;
	result_t skid_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (dn_rdy || !out_vld_q) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= up_vld;
			end
		end else if (up_vld && !skid_vld_q) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dn_rdy || !out_vld_q) begin
			out_data_q <= skid_vld_q ? skid_data_q : up_data;
		end else if (!skid_vld_q) begin
			skid_data_q <= up_data;
		end
	end

	assign up_rdy  = !skid_vld_q;
	assign dn_vld  = out_vld_q;
	assign dn_data = out_data_q;

endmodule

`default_nettype wire

// ===== hdl/rmsprop_parameter_update.sv =====
// Top level of the RMSprop parameter update: configuration registers, the
// mean square stages and the final step stage. Uses rmsp_pkg, rmsp_isqrt,
// rmsp_divider and rmsp_skid.
//
// One request is taken every cycle while in_ready is high, and each request
// gives exactly one result in order. On its way to out_valid it passes four
// stages that form the squared gradient, the rate product and the new mean
// square, 25 stages that take the square root one bit at a time, 33 stages
// that check the range and divide out the step one quotient bit at a time,
// one stage that applies the step and one output register for the result.
// in_ready falls only once a stalled output has also filled its skid stage.
`default_nettype none

module rmsprop_parameter_update import rmsp_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_write,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [RATE_W-1:0]        cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [PARAM_W-1:0] param_value,
	input  wire logic signed [PARAM_W-1:0] gradient,
	input  wire logic [MS_W-1:0]          mean_square,
	input  wire logic [RATE_W-1:0]        element_rate,
	input  wire logic                     is_last_in,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [PARAM_W-1:0]     new_param,
	output logic [MS_W-1:0]               new_mean_square,
	output logic                          saturated,
	output logic                          is_last_out
);

	localparam int unsigned SHIFT = 24 - FRAC_BITS;
	localparam logic [63:0] EPS_RAW =
		((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;
	localparam logic [RAD_W-1:0] EPS =
		(EPS_RAW == 64'd0) ? {{(RAD_W-1){1'b0}}, 1'b1} : EPS_RAW[RAD_W-1:0];

	logic [RATE_W-1:0]  base_rate_q;
	logic [DECAY_W-1:0] decay_q;
	logic               use_element_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_rate_q        <= BASE_RATE_RESET;
			decay_q            <= DECAY_RESET;
			use_element_rate_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_BASE_RATE: base_rate_q <= cfg_data;
				CFG_DECAY:     decay_q <= cfg_data[DECAY_W-1:0];
				CFG_ELEM_RATE: use_element_rate_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic adv;

	// Stage 1: magnitude of the gradient, rate choice and decay weights.
	logic                      vld_s1;
	logic signed [PARAM_W-1:0] t_s1;
	logic                      gneg_s1;
	logic [PARAM_W-1:0]        gmag_s1;
	logic [MS_W-1:0]           ms_s1;
	logic [RATE_W-1:0]         rate_s1;
	logic [DECAY_W-1:0]        d_s1;
	logic [DECAY_W-1:0]        e_s1;
	logic                      last_s1;
	logic [DECAY_W-1:0]        d_clip;

	assign d_clip = (decay_q > DECAY_ONE) ? DECAY_ONE : decay_q;

	// Stage 2: squared gradient, rate product and the mean square times decay.
	logic                      vld_s2;
	logic signed [PARAM_W-1:0] t_s2;
	logic                      gneg_s2;
	logic [DECAY_W-1:0]        e_s2;
	logic [PROD_W-1:0]         g2_s2;
	logic [PROD_W-1:0]         numer_s2;
	logic [48:0]               rdh_s2;
	logic [32:0]               rdl_s2;
	logic                      last_s2;
	logic [PROD_W-1:0]         prod;

	assign prod = PROD_W'(rate_s1) * PROD_W'(gmag_s1);

	// Stage 3: squared gradient times (1 - decay).
	logic                      vld_s3;
	logic signed [PARAM_W-1:0] t_s3;
	logic                      gneg_s3;
	logic [PROD_W-1:0]         ae_s3;
	logic [33:0]               lo_s3;
	logic [48:0]               rdh_s3;
	logic [PROD_W-1:0]         numer_s3;
	logic                      last_s3;
	logic [64:0]               ae_full;
	logic [32:0]               al_e;

	assign ae_full = g2_s2[PROD_W-1:16] * e_s2;
	assign al_e    = g2_s2[15:0] * e_s2;

	// Stage 4: new mean square, its clipping, and the square root operand.
	logic                      vld_s4;
	logic [RAD_W-1:0]          rad_s4;
	side_t                     side_s4;
	logic [PROD_W-1:0]         rn;
	logic                      rn_sat;
	logic [MS_W-1:0]           rn_clip;

	assign rn = ae_s3 + PROD_W'(rdh_s3) + PROD_W'(lo_s3[33:16]);
	assign rn_sat  = |rn[PROD_W-1:MS_W];
	assign rn_clip = rn_sat ? {MS_W{1'b1}} : rn[MS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1    <= param_value;
			gneg_s1 <= gradient[PARAM_W-1];
			gmag_s1 <= gradient[PARAM_W-1] ? PARAM_W'(-gradient) : gradient;
			ms_s1   <= mean_square;
			rate_s1 <= use_element_rate_q ? element_rate : base_rate_q;
			d_s1    <= d_clip;
			e_s1    <= DECAY_ONE - d_clip;
			last_s1 <= is_last_in;

			t_s2     <= t_s1;
			gneg_s2  <= gneg_s1;
			e_s2     <= e_s1;
			g2_s2    <= PROD_W'(gmag_s1) * PROD_W'(gmag_s1);
			numer_s2 <= prod >> SHIFT;
			rdh_s2   <= ms_s1[MS_W-1:16] * d_s1;
			rdl_s2   <= ms_s1[15:0] * d_s1;
			last_s2  <= last_s1;

			t_s3     <= t_s2;
			gneg_s3  <= gneg_s2;
			ae_s3    <= ae_full[PROD_W-1:0];
			lo_s3    <= 34'(al_e) + 34'(rdl_s2);
			rdh_s3   <= rdh_s2;
			numer_s3 <= numer_s2;
			last_s3  <= last_s2;

			rad_s4              <= RAD_W'(rn_clip) + EPS;
			side_s4.numer       <= numer_s3;
			side_s4.post.param  <= t_s3;
			side_s4.post.gneg   <= gneg_s3;
			side_s4.post.ms     <= rn_clip;
			side_s4.post.ms_sat <= rn_sat;
			side_s4.post.last   <= last_s3;
		end
	end

	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	side_t             sq_side;

	rmsp_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (vld_s4),
		.radicand (rad_s4),
		.side_in  (side_s4),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.side_out (sq_side)
	);

	logic              dv_vld;
	logic [QUOT_W-1:0] dv_quot;
	logic              dv_ovf;
	post_t             dv_post;

	rmsp_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (sq_vld),
		.numer    (sq_side.numer),
		.divisor  (sq_root),
		.post_in  (sq_side.post),
		.out_vld  (dv_vld),
		.quot     (dv_quot),
		.ovf      (dv_ovf),
		.post_out (dv_post)
	);

	// Stage 5: apply the step with the sign of the gradient and clip.
	logic        vld_s5;
	result_t     res_s5;
	logic [33:0] t_wide;
	logic [33:0] tn;
	logic        tn_clip;
	result_t     res_nxt;

	assign t_wide = {{2{dv_post.param[PARAM_W-1]}}, dv_post.param};
	assign tn     = dv_post.gneg ? (t_wide + {2'b00, dv_quot}) : (t_wide - {2'b00, dv_quot});
	assign tn_clip = (tn[33:31] != 3'b000) && (tn[33:31] != 3'b111);

	always_comb begin
		res_nxt.ms   = dv_post.ms;
		res_nxt.last = dv_post.last;
		if (dv_ovf || tn_clip) begin
			// A negative gradient pushes the parameter up, a positive one down.
			res_nxt.param = dv_post.gneg ? {1'b0, {(PARAM_W-1){1'b1}}}
				: {1'b1, {(PARAM_W-1){1'b0}}};
			res_nxt.sat   = 1'b1;
		end else begin
			res_nxt.param = tn[PARAM_W-1:0];
			res_nxt.sat   = dv_post.ms_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s5 <= res_nxt;
		end
	end

	result_t out_data;

	rmsp_skid u_skid (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_vld  (vld_s5),
		.up_data (res_s5),
		.up_rdy  (adv),
		.dn_vld  (out_valid),
		.dn_rdy  (out_ready),
		.dn_data (out_data)
	);

	assign in_ready        = adv;
	assign new_param       = out_data.param;
	assign new_mean_square = out_data.ms;
	assign saturated       = out_data.sat;
	assign is_last_out     = out_data.last;

endmodule

`default_nettype wire
